@@ rtl/core/crbl_pkg.sv @@
package crbl_pkg;

    localparam int DATA_W           = 18;
    localparam int NUM_BREAKS       = 8;
    localparam int CFG_IDX_W        = 4;
    localparam int METAL_ROWS_DEF   = 8;
    localparam int TEMP_COLUMNS_DEF = 91;

    // Q5.12 fixed point
    localparam int Q_SHIFT = 12;
    localparam int Q_ONE   = 4096;

    // temperature grid: 0.05 steps from 4.0, position = offset * 20 in Q12 columns
    localparam logic signed [DATA_W-1:0] T_FLOOR = 18'sd16384;
    localparam int TOFS_W     = DATA_W - 1;
    localparam int GRID_RECIP = 20;
    localparam int POS_W      = 22;

    localparam int DIFF_W = DATA_W + 1;
    localparam int WT_W   = DATA_W;
    localparam int WGT_W  = DIFF_W + 1;
    localparam int RA_W   = 42;
    localparam int SPLIT  = 21;
    localparam int ACC_W  = 64;
    localparam int DEN_W  = 32;
    localparam int REM_W  = DEN_W + DATA_W;
    localparam int DIV_STEPS = DATA_W;

    localparam logic signed [DATA_W-1:0] OUT_MAX = 18'sd131071;
    localparam logic signed [DATA_W-1:0] OUT_MIN = -18'sd131072;

    localparam logic signed [DATA_W-1:0] BREAK_RESET [NUM_BREAKS] = '{
        -18'sd27439, -18'sd19247, -18'sd15151, -18'sd13103,
        -18'sd11055, -18'sd9007,  -18'sd6959,  -18'sd4911
    };

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    // metallicity weights of one query
    typedef struct packed {
        logic                    use_den;
        logic [WT_W-1:0]         den;
        logic signed [WGT_W-1:0] wa;
        logic signed [WGT_W-1:0] wb;
    } weight_t;

    typedef struct packed {
        logic                    start;
        logic signed [ACC_W-1:0] num;
        logic [DEN_W-1:0]        den;
    } div_req_t;

    typedef struct packed {
        logic                     done;
        logic                     sat;
        logic signed [DATA_W-1:0] quot;
    } div_rsp_t;

endpackage

@@ rtl/core/crbl_if.sv @@
interface crbl_item_if import crbl_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic                     operation;
    logic [2:0]               row_select;
    logic [6:0]               column_select;
    logic signed [DATA_W-1:0] entry_value;
    logic signed [DATA_W-1:0] log_temp;
    logic signed [DATA_W-1:0] log_metal;

    modport source (output valid, operation, row_select, column_select, entry_value,
                    log_temp, log_metal, input ready);
    modport sink (input valid, operation, row_select, column_select, entry_value,
                  log_temp, log_metal, output ready);
endinterface

interface crbl_result_if import crbl_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic                     is_answer;
    logic signed [DATA_W-1:0] log_rate;
    logic                     saturated;

    modport source (output valid, is_answer, log_rate, saturated, input ready);
    modport sink (input valid, is_answer, log_rate, saturated, output ready);
endinterface

interface crbl_cfg_if import crbl_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_W-1:0]     index;
    logic signed [DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/crbl_regs.sv @@
module crbl_regs import crbl_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    crbl_cfg_if.sink                 cfg,
    output logic signed [DATA_W-1:0] brk [NUM_BREAKS]
);

    logic signed [DATA_W-1:0] brk_reg [NUM_BREAKS];

    assign cfg.ready = 1'b1;

    // indexes past the last breakpoint are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brk_reg <= BREAK_RESET;
        end
        else if (cfg.valid && (int'(cfg.index) < NUM_BREAKS))
        begin
            brk_reg[cfg.index[$clog2(NUM_BREAKS)-1:0]] <= cfg.data;
        end
    end

    assign brk = brk_reg;

endmodule

@@ rtl/core/crbl_locate.sv @@
module crbl_locate import crbl_pkg::*;
#(
    parameter int METAL_ROWS   = METAL_ROWS_DEF,
    parameter int TEMP_COLUMNS = TEMP_COLUMNS_DEF,
    localparam int ROW_W = $clog2(METAL_ROWS),
    localparam int COL_W = $clog2(TEMP_COLUMNS)
)
(
    input  logic signed [DATA_W-1:0] log_temp,
    input  logic signed [DATA_W-1:0] log_metal,
    input  logic signed [DATA_W-1:0] brk [NUM_BREAKS],
    output logic [COL_W-1:0]         col,
    output logic [ROW_W-1:0]         row,
    output logic [POS_W-1:0]         frac,
    output weight_t                  wt
);

    localparam int RAW_W = POS_W - Q_SHIFT;

    logic signed [DATA_W-1:0] t_cl;
    logic [TOFS_W-1:0]        t_ofs;
    logic [POS_W-1:0]         pos;
    logic [RAW_W-1:0]         col_raw;
    logic signed [DATA_W-1:0] z_lo;
    logic signed [DATA_W-1:0] z;
    logic                     run;
    logic [ROW_W-1:0]         row_hi;
    logic signed [DATA_W-1:0] b_lo;
    logic signed [DATA_W-1:0] b_hi;
    logic signed [DIFF_W-1:0] den_s;
    logic signed [DIFF_W-1:0] num_s;

    // temperature column; top columns extrapolate from the last pair
    always_comb
    begin
        t_cl    = (log_temp < T_FLOOR) ? T_FLOOR : log_temp;
        t_ofs   = TOFS_W'(t_cl - T_FLOOR);
        pos     = POS_W'(t_ofs) * POS_W'(GRID_RECIP);
        col_raw = pos[POS_W-1:Q_SHIFT];
        if (col_raw >= RAW_W'(TEMP_COLUMNS - 1))
            col = COL_W'(TEMP_COLUMNS - 2);
        else
            col = col_raw[COL_W-1:0];
        frac = pos - (POS_W'(col) << Q_SHIFT);
    end

    // metallicity clamp, then the lowest row whose upper break is not below z
    always_comb
    begin
        z_lo = (log_metal < brk[0]) ? brk[0] : log_metal;
        z    = (z_lo > brk[METAL_ROWS-1]) ? brk[METAL_ROWS-1] : z_lo;
        row  = '0;
        run  = 1'b1;
        for (int k = 1; k <= METAL_ROWS - 2; k++)
        begin
            if (run && (z > brk[k]))
                row = ROW_W'(k);
            else
                run = 1'b0;
        end
        row_hi = row + 1'b1;
        b_lo   = brk[row];
        b_hi   = brk[row_hi];
        den_s  = DIFF_W'(b_hi) - DIFF_W'(b_lo);
        num_s  = DIFF_W'(z) - DIFF_W'(b_lo);
        // num <= den; num goes negative when the top break lies below the bottom one
        wt.use_den = (den_s > DIFF_W'(0));
        wt.den     = den_s[WT_W-1:0];
        wt.wb      = WGT_W'(num_s);
        wt.wa      = WGT_W'(den_s) - WGT_W'(num_s);
    end

endmodule

@@ rtl/core/crbl_ram.sv @@
module crbl_ram import crbl_pkg::*;
#(
    parameter int DEPTH  = METAL_ROWS_DEF * TEMP_COLUMNS_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [ADDR_W-1:0]        addr,
    input  logic signed [DATA_W-1:0] wdata,
    output logic signed [DATA_W-1:0] rdata
);

    logic signed [DATA_W-1:0] mem [DEPTH];
    logic signed [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/crbl_div.sv @@
module crbl_div import crbl_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CNT_W = $clog2(DIV_STEPS + 1);

    logic [ACC_W-1:0]        lim;
    logic [ACC_W-1:0]        top;
    logic signed [ACC_W-1:0] x;
    logic                    neg;
    logic                    over;
    logic                    ge;

    logic [REM_W-1:0]  rem_reg;
    logic [REM_W-1:0]  dsh_reg;
    logic [DATA_W-1:0] q_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              done_reg;
    logic              sat_reg;
    logic              hi_reg;

    // floor(num/den) is offset by 2^17 so the quotient is an 18-bit unsigned value
    always_comb
    begin
        lim  = ACC_W'(req.den) << (DATA_W - 1);
        top  = ACC_W'(req.den) << DATA_W;
        x    = req.num + $signed(lim);
        neg  = x[ACC_W-1];
        over = !neg && ($unsigned(x) >= top);
        ge   = (rem_reg >= dsh_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
            sat_reg  <= 1'b0;
            hi_reg   <= 1'b0;
        end
        else if (req.start)
        begin
            sat_reg  <= neg || over;
            hi_reg   <= over;
            cnt_reg  <= (neg || over) ? CNT_W'(0) : CNT_W'(DIV_STEPS);
            done_reg <= neg || over;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            done_reg <= (cnt_reg == CNT_W'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // one quotient bit per cycle, restoring
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= x[REM_W-1:0];
            dsh_reg <= lim[REM_W-1:0];
            q_reg   <= '0;
        end
        else if (cnt_reg != '0)
        begin
            if (ge)
                rem_reg <= rem_reg - dsh_reg;
            dsh_reg <= dsh_reg >> 1;
            q_reg   <= {q_reg[DATA_W-2:0], ge};
        end
    end

    always_comb
    begin
        rsp.done = done_reg;
        rsp.sat  = sat_reg;
        if (sat_reg)
            rsp.quot = hi_reg ? OUT_MAX : OUT_MIN;
        else
            rsp.quot = $signed({~q_reg[DATA_W-1], q_reg[DATA_W-2:0]});
    end

endmodule

@@ rtl/core/cooling_rate_bilinear_lookup.sv @@
// Cooling-rate table with bilinear lookup, log10 rates in signed Q5.12.
// item channel: one request either writes a table entry (operation 0) or asks
// a query with log temperature and log metallicity (operation 1). Every
// request gives exactly one response on the result channel: an acknowledge
// with is_answer low and zero payload for a write, the interpolated and
// saturated log rate for a query. cfg channel: breakpoint registers 0..7,
// always ready. The user must write them only while no request is in
// flight; the block itself does not enforce this. Requests are handled
// one at a time. A write goes from its write state to the done state. A
// query takes four reads of the single-port table, six passes through one
// shared 23x20 multiplier, and the bit-serial divider that normalizes by
// the metallicity span. With misordered or equal breaks, the
// multiply-accumulate is skipped; a result that clips is known before
// division and skips the divider's bit steps. The next request is taken
// in the cycle the response becomes valid.
// The result sits in an output register; a stalled receiver holds it there,
// and a following request is still taken and worked on up to its own result.
// Reset clears the control state and restores the breakpoints; the table is
// not cleared and entries must be written before they are queried.
module cooling_rate_bilinear_lookup import crbl_pkg::*;
#(
    parameter int METAL_ROWS   = METAL_ROWS_DEF,
    parameter int TEMP_COLUMNS = TEMP_COLUMNS_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    crbl_item_if.sink     item,
    crbl_result_if.source result,
    crbl_cfg_if.sink      cfg
);

    localparam int ROW_W  = $clog2(METAL_ROWS);
    localparam int COL_W  = $clog2(TEMP_COLUMNS);
    localparam int DEPTH  = METAL_ROWS * TEMP_COLUMNS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int MA_W   = POS_W + 1;
    localparam int MB_W   = DIFF_W + 1;
    localparam int PROD_W = MA_W + MB_W;

    typedef enum logic [4:0] {
        S_IDLE,
        S_WRITE,
        S_PREP,
        S_RD_A0,
        S_RD_A1,
        S_RD_B0,
        S_RD_B1,
        S_ROW_A,
        S_ROW_B,
        S_ROW_END,
        S_MAC0,
        S_MAC1,
        S_MAC2,
        S_MAC3,
        S_MAC_END,
        S_DIV_GO,
        S_DIV_WAIT,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic signed [DATA_W-1:0] brk [NUM_BREAKS];

    logic [COL_W-1:0] loc_col;
    logic [ROW_W-1:0] loc_row;
    logic [POS_W-1:0] loc_frac;
    weight_t          loc_wt;

    op_t                      op_reg;
    logic [2:0]               wrow_reg;
    logic [6:0]               wcol_reg;
    logic signed [DATA_W-1:0] wval_reg;
    logic signed [DATA_W-1:0] ltemp_reg;
    logic signed [DATA_W-1:0] lmetal_reg;

    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic [POS_W-1:0] frac_reg;
    weight_t          wt_reg;

    logic signed [DATA_W-1:0] e_a0_reg;
    logic signed [DATA_W-1:0] e_a1_reg;
    logic signed [DATA_W-1:0] e_b0_reg;
    logic signed [DATA_W-1:0] e_b1_reg;
    logic signed [RA_W-1:0]   ra_reg;
    logic signed [RA_W-1:0]   rb_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    logic                     out_valid_reg;
    logic                     out_answer_reg;
    logic signed [DATA_W-1:0] out_rate_reg;
    logic                     out_sat_reg;

    logic signed [DIFF_W-1:0] diff_a;
    logic signed [DIFF_W-1:0] diff_b;
    logic signed [MA_W-1:0]   mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic signed [PROD_W-1:0] mul_p;

    logic [ADDR_W-1:0]        base_addr;
    logic [ADDR_W-1:0]        wr_addr;
    logic                     wr_ok;
    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_addr;
    logic signed [DATA_W-1:0] ram_rdata;

    logic [Q_SHIFT+WT_W-1:0]  d_scaled;
    div_req_t                 div_req;
    div_rsp_t                 div_rsp;

    logic                     accept;
    logic                     slot_free;
    logic                     load;

    crbl_regs u_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .brk   (brk)
    );

    crbl_locate #(
        .METAL_ROWS   (METAL_ROWS),
        .TEMP_COLUMNS (TEMP_COLUMNS)
    ) u_locate (
        .log_temp  (ltemp_reg),
        .log_metal (lmetal_reg),
        .brk       (brk),
        .col       (loc_col),
        .row       (loc_row),
        .frac      (loc_frac),
        .wt        (loc_wt)
    );

    crbl_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (wval_reg),
        .rdata (ram_rdata)
    );

    crbl_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign accept    = item.valid && item.ready;
    assign slot_free = !out_valid_reg || result.ready;
    assign load      = (state_reg == S_DONE) && slot_free;

    assign item.ready       = (state_reg == S_IDLE);
    assign result.valid     = out_valid_reg;
    assign result.is_answer = out_answer_reg;
    assign result.log_rate  = out_rate_reg;
    assign result.saturated = out_sat_reg;

    // table addressing: row-major, four neighbors around (row, col)
    always_comb
    begin
        base_addr = ADDR_W'(row_reg) * ADDR_W'(TEMP_COLUMNS) + ADDR_W'(col_reg);
        wr_addr   = ADDR_W'(wrow_reg) * ADDR_W'(TEMP_COLUMNS) + ADDR_W'(wcol_reg);
        wr_ok     = (int'(wrow_reg) < METAL_ROWS) && (int'(wcol_reg) < TEMP_COLUMNS);
        ram_we    = (state_reg == S_WRITE) && wr_ok;
        case (state_reg)
            S_WRITE: ram_addr = wr_addr;
            S_RD_A1: ram_addr = base_addr + ADDR_W'(1);
            S_RD_B0: ram_addr = base_addr + ADDR_W'(TEMP_COLUMNS);
            S_RD_B1: ram_addr = base_addr + ADDR_W'(TEMP_COLUMNS + 1);
            default: ram_addr = base_addr;
        endcase
    end

    // shared multiplier: row slopes, then the metallicity weights on split row values
    always_comb
    begin
        diff_a = DIFF_W'(e_a1_reg) - DIFF_W'(e_a0_reg);
        diff_b = DIFF_W'(e_b1_reg) - DIFF_W'(e_b0_reg);
        case (state_reg)
            S_ROW_A:
            begin
                mul_a = $signed(MA_W'(frac_reg));
                mul_b = MB_W'(diff_a);
            end
            S_ROW_B:
            begin
                mul_a = $signed(MA_W'(frac_reg));
                mul_b = MB_W'(diff_b);
            end
            S_MAC0:
            begin
                mul_a = MA_W'($signed(ra_reg[RA_W-1:SPLIT]));
                mul_b = $signed(MB_W'(wt_reg.wa));
            end
            S_MAC1:
            begin
                mul_a = $signed(MA_W'(ra_reg[SPLIT-1:0]));
                mul_b = $signed(MB_W'(wt_reg.wa));
            end
            S_MAC2:
            begin
                mul_a = MA_W'($signed(rb_reg[RA_W-1:SPLIT]));
                mul_b = $signed(MB_W'(wt_reg.wb));
            end
            S_MAC3:
            begin
                mul_a = $signed(MA_W'(rb_reg[SPLIT-1:0]));
                mul_b = $signed(MB_W'(wt_reg.wb));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // rounding: floor((2*total + d) / (2*d)), d = span * 4096, or 4096 alone
    always_comb
    begin
        d_scaled      = {wt_reg.den, {Q_SHIFT{1'b0}}};
        div_req.start = (state_reg == S_DIV_GO);
        if (wt_reg.use_den)
        begin
            div_req.num = (acc_reg <<< 1) + $signed(ACC_W'(d_scaled));
            div_req.den = DEN_W'(d_scaled) << 1;
        end
        else
        begin
            div_req.num = (ACC_W'(ra_reg) <<< 1) + ACC_W'(Q_ONE);
            div_req.den = DEN_W'(2 * Q_ONE);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (item.valid)
                    state_next = (op_t'(item.operation) == OP_QUERY) ? S_PREP : S_WRITE;
            end
            S_WRITE:    state_next = S_DONE;
            S_PREP:     state_next = S_RD_A0;
            S_RD_A0:    state_next = S_RD_A1;
            S_RD_A1:    state_next = S_RD_B0;
            S_RD_B0:    state_next = S_RD_B1;
            S_RD_B1:    state_next = S_ROW_A;
            S_ROW_A:    state_next = S_ROW_B;
            S_ROW_B:    state_next = S_ROW_END;
            S_ROW_END:  state_next = wt_reg.use_den ? S_MAC0 : S_DIV_GO;
            S_MAC0:     state_next = S_MAC1;
            S_MAC1:     state_next = S_MAC2;
            S_MAC2:     state_next = S_MAC3;
            S_MAC3:     state_next = S_MAC_END;
            S_MAC_END:  state_next = S_DIV_GO;
            S_DIV_GO:   state_next = S_DIV_WAIT;
            S_DIV_WAIT:
            begin
                if (div_rsp.done)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (slot_free)
                    state_next = S_IDLE;
            end
            default:    state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            out_answer_reg <= 1'b0;
            out_rate_reg   <= '0;
            out_sat_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load)
            begin
                out_valid_reg  <= 1'b1;
                out_answer_reg <= (op_reg == OP_QUERY);
                out_rate_reg   <= (op_reg == OP_QUERY) ? div_rsp.quot : '0;
                out_sat_reg    <= (op_reg == OP_QUERY) && div_rsp.sat;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath; read data arrives in the cycle after its address
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p;
        if (accept)
        begin
            op_reg     <= op_t'(item.operation);
            wrow_reg   <= item.row_select;
            wcol_reg   <= item.column_select;
            wval_reg   <= item.entry_value;
            ltemp_reg  <= item.log_temp;
            lmetal_reg <= item.log_metal;
        end
        case (state_reg)
            S_PREP:
            begin
                col_reg  <= loc_col;
                row_reg  <= loc_row;
                frac_reg <= loc_frac;
                wt_reg   <= loc_wt;
            end
            S_RD_A1:   e_a0_reg <= ram_rdata;
            S_RD_B0:   e_a1_reg <= ram_rdata;
            S_RD_B1:   e_b0_reg <= ram_rdata;
            S_ROW_A:   e_b1_reg <= ram_rdata;
            S_ROW_B:   ra_reg <= (RA_W'(e_a0_reg) <<< Q_SHIFT) + RA_W'(prod_reg);
            S_ROW_END: rb_reg <= (RA_W'(e_b0_reg) <<< Q_SHIFT) + RA_W'(prod_reg);
            S_MAC0:    acc_reg <= '0;
            S_MAC1:    acc_reg <= acc_reg + (ACC_W'(prod_reg) <<< SPLIT);
            S_MAC2:    acc_reg <= acc_reg + ACC_W'(prod_reg);
            S_MAC3:    acc_reg <= acc_reg + (ACC_W'(prod_reg) <<< SPLIT);
            S_MAC_END: acc_reg <= acc_reg + ACC_W'(prod_reg);
            default:
            begin
            end
        endcase
    end

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !item.ready)
        else $error("request taken while a previous request is in flight");

    a_ack_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.is_answer |-> (result.log_rate == '0) && !result.saturated)
        else $error("write acknowledge carries a payload");

    a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.saturated |->
            (result.log_rate == OUT_MAX) || (result.log_rate == OUT_MIN))
        else $error("saturated flag without a clipped rate");

    a_ram_write_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (int'(ram_addr) < DEPTH) && (state_reg == S_WRITE))
        else $error("table write outside the table");

endmodule

@@ sim/cooling_rate_bilinear_lookup_tb.sv @@
module cooling_rate_bilinear_lookup_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import crbl_pkg::*;

    localparam int ROWS             = METAL_ROWS_DEF;
    localparam int COLS             = TEMP_COLUMNS_DEF;
    localparam int PHASES           = 7;
    localparam int RANDOM_PER_PHASE = 135;
    localparam int WATCHDOG_LIMIT   = 5000;
    localparam int DRAIN_CYCLES     = 40;
    localparam int MAX_REPORTS      = 10;
    localparam int BREAK_STEP       = 37449;    // 7 steps span the full 18 bit range

    typedef struct {
        op_t                      operation;
        logic [2:0]               row_select;
        logic [6:0]               column_select;
        logic signed [DATA_W-1:0] entry_value;
        logic signed [DATA_W-1:0] log_temp;
        logic signed [DATA_W-1:0] log_metal;
    } lookup_request_t;

    typedef struct {
        logic                     is_answer;
        logic signed [DATA_W-1:0] log_rate;
        logic                     saturated;
    } rate_response_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    crbl_item_if   item_bus ();
    crbl_result_if result_bus ();
    crbl_cfg_if    cfg_bus ();

    cooling_rate_bilinear_lookup DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_bus),
        .result (result_bus),
        .cfg    (cfg_bus)
    );

    logic signed [DATA_W-1:0] model_breaks [NUM_BREAKS];
    logic signed [DATA_W-1:0] model_table [ROWS*COLS];

    lookup_request_t pending_requests [$];
    rate_response_t  expected_rates [$];

    int error_count        = 0;
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int quiet_cycles       = 0;

    always #5 clk = ~clk;

    function automatic void report_error(string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("ERROR at %0t: %s", $time, msg);
    endfunction

    function automatic int rand_between(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    // Row value at the clamped temperature, unrounded Q24
    function automatic longint interp_row(int row, longint col, longint frac);
        longint e0;
        longint e1;
        e0 = model_table[row*COLS + int'(col)];
        e1 = model_table[row*COLS + int'(col) + 1];
        return e0 * Q_ONE + (e1 - e0) * frac;
    endfunction

    function automatic rate_response_t apply_request(lookup_request_t req);
        rate_response_t rsp;
        longint t, z, pos, col, frac, ra, rb, den, num, total, divisor, numer, q;
        int row;
        rsp.is_answer = 1'b0;
        rsp.log_rate  = '0;
        rsp.saturated = 1'b0;
        if (req.operation == OP_WRITE) begin
            // out of range coordinates are dropped, still acknowledged
            if (int'(req.row_select) < ROWS && int'(req.column_select) < COLS)
                model_table[int'(req.row_select)*COLS + int'(req.column_select)] =
                    req.entry_value;
            return rsp;
        end

        t = req.log_temp;
        if (t < T_FLOOR)
            t = T_FLOOR;
        pos = (t - T_FLOOR) * GRID_RECIP;
        col = pos >>> Q_SHIFT;
        if (col >= COLS - 1)
            col = COLS - 2;             // past the last column: extrapolate
        frac = pos - col * Q_ONE;

        z = req.log_metal;
        if (z < model_breaks[0])
            z = model_breaks[0];
        if (z > model_breaks[ROWS-1])
            z = model_breaks[ROWS-1];
        row = 0;
        while (row < ROWS - 2 && z > model_breaks[row+1])
            row++;

        ra  = interp_row(row, col, frac);
        rb  = interp_row(row + 1, col, frac);
        den = longint'(model_breaks[row+1]) - longint'(model_breaks[row]);
        num = z - longint'(model_breaks[row]);
        if (den > 0) begin
            total   = ra * den + (rb - ra) * num;
            divisor = den * Q_ONE;
        end
        else begin
            // misordered or equal breaks: lower row alone
            total   = ra;
            divisor = Q_ONE;
        end

        // nearest, halves toward +inf: floor((2*total + d) / (2*d))
        numer = 2 * total + divisor;
        q = numer / (2 * divisor);
        if (numer % (2 * divisor) != 0 && numer < 0)
            q--;

        rsp.is_answer = 1'b1;
        if (q > OUT_MAX) begin
            q = OUT_MAX;
            rsp.saturated = 1'b1;
        end
        else if (q < OUT_MIN) begin
            q = OUT_MIN;
            rsp.saturated = 1'b1;
        end
        rsp.log_rate = q[DATA_W-1:0];
        return rsp;
    endfunction

    function automatic lookup_request_t make_write(int row, int col, int value);
        lookup_request_t req;
        req.operation     = OP_WRITE;
        req.row_select    = 3'(row);
        req.column_select = 7'(col);
        req.entry_value   = DATA_W'(value);
        req.log_temp      = DATA_W'($urandom);
        req.log_metal     = DATA_W'($urandom);
        return req;
    endfunction

    function automatic lookup_request_t make_query(int temp, int metal);
        lookup_request_t req;
        req.operation     = OP_QUERY;
        req.row_select    = 3'($urandom);
        req.column_select = 7'($urandom);
        req.entry_value   = DATA_W'($urandom);
        req.log_temp      = DATA_W'(temp);
        req.log_metal     = DATA_W'(metal);
        return req;
    endfunction

    function automatic int random_entry();
        if ($urandom_range(9) < 7)
            return rand_between(-65536, 65535);
        return int'($urandom);
    endfunction

    function automatic lookup_request_t random_request();
        int pick;
        int temp;
        int metal;
        if ($urandom_range(99) < 25) begin
            if ($urandom_range(9) == 0)
                return make_write($urandom_range(7), $urandom_range(127), $urandom);
            return make_write($urandom_range(ROWS-1), $urandom_range(COLS-1), random_entry());
        end
        pick = $urandom_range(99);
        if (pick < 60)
            temp = rand_between(int'(T_FLOOR) - 2048, int'(T_FLOOR) + 19000);
        else if (pick < 75)
            temp = rand_between(int'(T_FLOOR) + 18000, int'(OUT_MAX));
        else
            temp = int'($urandom);
        if ($urandom_range(99) < 70) begin
            metal = int'(model_breaks[$urandom_range(NUM_BREAKS-1)]) + rand_between(-4096, 4096);
            if (metal > int'(OUT_MAX))
                metal = OUT_MAX;
            if (metal < int'(OUT_MIN))
                metal = OUT_MIN;
        end
        else
            metal = int'($urandom);
        return make_query(temp, metal);
    endfunction

    task automatic program_breaks(input logic signed [DATA_W-1:0] values [NUM_BREAKS],
                                  input bit add_unused);
        logic [CFG_IDX_W-1:0]     idx_list [$];
        logic signed [DATA_W-1:0] data_list [$];
        if (add_unused) begin
            // indexes past the last break must be ignored
            idx_list.push_back(CFG_IDX_W'(NUM_BREAKS));
            data_list.push_back(DATA_W'($urandom));
            idx_list.push_back({CFG_IDX_W{1'b1}});
            data_list.push_back(DATA_W'($urandom));
        end
        for (int k = 0; k < NUM_BREAKS; k++) begin
            idx_list.push_back(CFG_IDX_W'(k));
            data_list.push_back(values[k]);
        end
        @(posedge clk);
        foreach (idx_list[n]) begin
            cfg_bus.valid <= 1'b1;
            cfg_bus.index <= idx_list[n];
            cfg_bus.data  <= data_list[n];
            @(posedge clk);
            while (!cfg_bus.ready)
                @(posedge clk);
            if (int'(idx_list[n]) < NUM_BREAKS)
                model_breaks[idx_list[n]] = data_list[n];
        end
        cfg_bus.valid <= 1'b0;
    endtask

    // request driver
    always @(posedge clk) begin : drive_requests
        lookup_request_t driven_req;
        if (rst_n) begin
            if (item_bus.valid && item_bus.ready)
                expected_rates.push_back(apply_request(driven_req));
            if (!item_bus.valid || item_bus.ready) begin
                if (pending_requests.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
                    driven_req = pending_requests.pop_front();
                    item_bus.valid         <= 1'b1;
                    item_bus.operation     <= driven_req.operation;
                    item_bus.row_select    <= driven_req.row_select;
                    item_bus.column_select <= driven_req.column_select;
                    item_bus.entry_value   <= driven_req.entry_value;
                    item_bus.log_temp      <= driven_req.log_temp;
                    item_bus.log_metal     <= driven_req.log_metal;
                end
                else
                    item_bus.valid <= 1'b0;
            end
        end
    end

    // response checker
    always @(posedge clk) begin : check_responses
        rate_response_t want;
        if (rst_n) begin
            if (result_bus.valid && result_bus.ready) begin
                if (expected_rates.size() == 0)
                    report_error($sformatf("unexpected response: is_answer %0b log_rate %0d sat %0b",
                                           result_bus.is_answer, result_bus.log_rate,
                                           result_bus.saturated));
                else begin
                    want = expected_rates.pop_front();
                    if (result_bus.is_answer !== want.is_answer ||
                        result_bus.log_rate !== want.log_rate ||
                        result_bus.saturated !== want.saturated)
                        report_error($sformatf(
                            "expected is_answer %0b log_rate %0d sat %0b, got %0b %0d %0b",
                            want.is_answer, want.log_rate, want.saturated,
                            result_bus.is_answer, result_bus.log_rate, result_bus.saturated));
                end
            end
            result_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    always @(posedge clk) begin : watchdog
        if (rst_n) begin
            if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready) ||
                (cfg_bus.valid && cfg_bus.ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("cooling_rate_bilinear_lookup test failed");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        logic signed [DATA_W-1:0] next_breaks [NUM_BREAKS];
        int v;
        item_bus.valid         = 1'b0;
        item_bus.operation     = OP_WRITE;
        item_bus.row_select    = '0;
        item_bus.column_select = '0;
        item_bus.entry_value   = '0;
        item_bus.log_temp      = '0;
        item_bus.log_metal     = '0;
        result_bus.ready       = 1'b0;
        cfg_bus.valid          = 1'b0;
        cfg_bus.index          = '0;
        cfg_bus.data           = '0;
        model_breaks           = BREAK_RESET;
        foreach (model_table[n])
            model_table[n] = '0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 81; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 81; end
                default: begin sender_idle_pct = 21; receiver_stall_pct = 21; end
            endcase

            if (phase > 0) begin
                case (phase)
                    1: for (int k = 0; k < NUM_BREAKS; k++)
                           next_breaks[k] = DATA_W'(int'(OUT_MIN) + k*BREAK_STEP);
                    2: next_breaks = '{-18'sd20000, -18'sd20000, -18'sd10000, -18'sd12000,
                                       18'sd0, 18'sd4096, 18'sd4096, 18'sd60000};
                    3: for (int k = 0; k < NUM_BREAKS; k++)
                           next_breaks[k] = DATA_W'(int'(OUT_MAX) - k*BREAK_STEP);
                    4: begin
                        v = rand_between(int'(OUT_MIN), -60000);
                        for (int k = 0; k < NUM_BREAKS; k++) begin
                            next_breaks[k] = DATA_W'(v);
                            v += rand_between(1, 20000);
                        end
                    end
                    5: for (int k = 0; k < NUM_BREAKS; k++)
                           next_breaks[k] = DATA_W'($urandom);
                    default: next_breaks = BREAK_RESET;
                endcase
                program_breaks(next_breaks, phase == PHASES - 1);
            end

            if (phase == 0) begin
                // every entry gets written before anything is queried
                for (int r = 0; r < ROWS; r++)
                    for (int c = 0; c < COLS; c++)
                        pending_requests.push_back(make_write(r, c, random_entry()));

                pending_requests.push_back(make_write(0, 0, OUT_MIN));
                pending_requests.push_back(make_write(7, 90, OUT_MAX));
                pending_requests.push_back(make_write(3, 127, OUT_MAX));
                pending_requests.push_back(make_write(5, COLS, OUT_MIN));
                pending_requests.push_back(make_query(OUT_MIN, OUT_MIN));
                pending_requests.push_back(make_query(OUT_MAX, OUT_MAX));
                pending_requests.push_back(make_query(T_FLOOR, model_breaks[3]));
                pending_requests.push_back(make_query(34815, model_breaks[1] + 1));
                pending_requests.push_back(make_query(34816, model_breaks[6] - 1));
                pending_requests.push_back(make_query(int'(T_FLOOR) + 10000, -17000));
                // extrapolation past the last column driven into clipping, both signs
                pending_requests.push_back(make_write(6, 89, 0));
                pending_requests.push_back(make_write(6, 90, 0));
                pending_requests.push_back(make_write(7, 89, OUT_MIN));
                pending_requests.push_back(make_query(OUT_MAX, OUT_MAX));
                pending_requests.push_back(make_write(7, 89, OUT_MAX));
                pending_requests.push_back(make_write(7, 90, OUT_MIN));
                pending_requests.push_back(make_query(OUT_MAX, OUT_MAX));
                // column 2 at half fraction: +0.5 LSB rounds up, -0.5 LSB rounds to zero
                pending_requests.push_back(make_write(0, 2, 0));
                pending_requests.push_back(make_write(0, 3, 1));
                pending_requests.push_back(make_query(int'(T_FLOOR) + 512, OUT_MIN));
                pending_requests.push_back(make_write(0, 3, -1));
                pending_requests.push_back(make_query(int'(T_FLOOR) + 512, OUT_MIN));
            end

            // probe each breakpoint and both corners under the current breaks
            for (int k = 0; k < NUM_BREAKS; k++)
                pending_requests.push_back(make_query(
                    rand_between(int'(T_FLOOR), int'(T_FLOOR) + 18000), model_breaks[k]));
            pending_requests.push_back(make_query(OUT_MIN, OUT_MIN));
            pending_requests.push_back(make_query(OUT_MAX, OUT_MAX));

            for (int n = 0; n < RANDOM_PER_PHASE; n++)
                pending_requests.push_back(random_request());

            while (!(pending_requests.size() == 0 && !item_bus.valid &&
                     expected_rates.size() == 0))
                @(posedge clk);
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && expected_rates.size() == 0)
            $display("cooling_rate_bilinear_lookup test passed");
        else
            $display("cooling_rate_bilinear_lookup test failed");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/crbl_pkg.sv
rtl/core/crbl_if.sv
rtl/core/crbl_regs.sv
rtl/core/crbl_locate.sv
rtl/core/crbl_ram.sv
rtl/core/crbl_div.sv
rtl/core/cooling_rate_bilinear_lookup.sv
sim/cooling_rate_bilinear_lookup_tb.sv
